FILE: rtl/ip_address_text_validator_assert.svh
// Assertion macros shared by the checker of the address text validator.
// Depends on nothing; included by the checker file only.
`ifndef IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH

// Condition a must be followed by condition b in the same cycle.
`define IPV_ASSERT_SAME(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Condition a must be followed by condition b in the next cycle.
`define IPV_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/ipv_pkg.sv
// Shared types, constants and helpers of the address text validator.
// Depends on nothing; imported by the front, back and top-level modules.
package ipv_pkg;

  // Character classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_DEC,
    CLS_HEX,
    CLS_DOT,
    CLS_COLON,
    CLS_END,
    CLS_OTHER
  } cls_e;

  // Head of the class queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cls_e cls;
  } q_head_t;

  // One finished verdict.
  typedef struct packed {
    logic v4;
    logic v6;
    logic any;
  } verdict_t;

  // Dotted-quad checker state.
  typedef struct packed {
    logic [1:0] digits;
    logic [2:0] groups;
    logic       failed;
  } v4_state_t;

  // Colon-hex checker state.
  typedef struct packed {
    logic [2:0] dec_cnt;
    logic [2:0] hex_cnt;
    logic [3:0] colon_groups;
    logic [2:0] dot_groups;
    logic       seen_double;
    logic       colon_pending;
    logic       failed;
  } v6_state_t;

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  // Group limits of both forms.
  localparam logic [1:0] V4_MAX_DIGITS      = 2'd3;
  localparam logic [2:0] V4_GROUPS          = 3'd4;
  localparam logic [3:0] V6_GROUP_DIGITS    = 4'd4;
  localparam logic [3:0] V6_GROUPS_FULL     = 4'd8;
  localparam logic [3:0] V6_GROUPS_DOUBLE   = 4'd7;
  localparam logic [3:0] V6_TAIL_MAX_GROUPS = 4'd6;
  localparam logic [2:0] V6_TAIL_DEC_MAX    = 3'd3;
  localparam logic [2:0] V6_TAIL_GROUPS     = 3'd4;

  // Saturating increments.
  function automatic logic [2:0] sat_inc3(input logic [2:0] v);
    return (v == 3'd7) ? v : v + 3'd1;
  endfunction

  function automatic logic [3:0] sat_inc4(input logic [3:0] v);
    return (v == 4'd15) ? v : v + 4'd1;
  endfunction

endpackage

FILE: rtl/ip_address_text_validator.sv
// Top level of the IPv4/IPv6 address text validator.
// Depends on ipv_pkg, ipv_front and ipv_back.
//
// Channel   Direction  Handshake          Payload
// input     in         push / full        text_char_i (8 bits, 0 ends a string)
// result    out        empty / pop        valid_v4_o, valid_v6_o, valid_any_o
//
// One character is taken every cycle while full is low.
// A terminator passes through the class queue and then into the result
// register, whose content shows on the ports; a waiting result holds it.
// Reset clears the queue, both checkers and the result valid flag.
// While a result waits, characters keep flowing into the checkers; only a
// second terminator stalls at the queue head, and full rises once the
// QDEPTH-entry queue fills behind it.
module ip_address_text_validator import ipv_pkg::*; #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_char_i,
  output logic       empty,
  input  logic       pop,
  output logic       valid_v4_o,
  output logic       valid_v6_o,
  output logic       valid_any_o
);

  q_head_t  head;
  logic     deq;
  logic     res_valid;
  verdict_t res;

  // Front end: classify and queue.
  ipv_front #(
    .DEPTH(QDEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .text_char_i(text_char_i),
    .full_o     (full),
    .head_o     (head),
    .deq_i      (deq)
  );

  // Back end: checkers and result register.
  ipv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .deq_o      (deq),
    .pop_i      (pop),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign empty       = !res_valid;
  assign valid_v4_o  = res.v4;
  assign valid_v6_o  = res.v6;
  assign valid_any_o = res.any;

endmodule

FILE: rtl/ipv_front.sv
// Front end: accepts characters, classifies them and queues the classes.
// Depends on ipv_pkg; instantiated by ip_address_text_validator.
module ipv_front import ipv_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] text_char_i,
  output logic       full_o,
  output q_head_t    head_o,
  input  logic       deq_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cls_e          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          wr_en;
  logic          rd_en;
  cls_e          cls;

  // Sort the incoming byte into its character class.
  always_comb begin
    if (text_char_i == CHAR_NUL) begin
      cls = CLS_END;
    end else if (text_char_i >= CHAR_0 && text_char_i <= CHAR_9) begin
      cls = CLS_DEC;
    end else if ((text_char_i >= CHAR_LA && text_char_i <= CHAR_LF) ||
                 (text_char_i >= CHAR_UA && text_char_i <= CHAR_UF)) begin
      cls = CLS_HEX;
    end else if (text_char_i == CHAR_DOT) begin
      cls = CLS_DOT;
    end else if (text_char_i == CHAR_COLON) begin
      cls = CLS_COLON;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign full_o       = (cnt_q == CW'(DEPTH));
  assign wr_en        = push_i && !full_o;
  assign rd_en        = deq_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cls   = mem_q[rd_ptr_q];

  // Pointer and fill-count update of the circular queue.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: rtl/ipv_back.sv
// Back end: runs both address checkers over queued classes and holds the verdict.
// Depends on ipv_pkg; instantiated by ip_address_text_validator.
module ipv_back import ipv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_head_t  head_i,
  output logic     deq_o,
  input  logic     pop_i,
  output logic     res_valid_o,
  output verdict_t res_o
);

  v4_state_t v4_q, v4_d;
  v6_state_t v6_q, v6_d;
  v6_state_t v6_nxt;
  logic      out_valid_q, out_valid_d;
  verdict_t  out_q, out_d;
  logic      is_end;
  logic      stop;
  logic      ok4, ok6;
  logic [3:0] digit_sum;

  assign is_end = (head_i.cls == CLS_END);
  assign deq_o  = head_i.valid && (!is_end || !out_valid_q || pop_i);

  // Dotted-quad checker step for one non-terminator class.
  always_comb begin
    v4_d = v4_q;
    if (!v4_q.failed) begin
      unique case (head_i.cls)
        CLS_DEC: begin
          if (v4_q.digits == 2'd0) begin
            v4_d.groups = sat_inc3(v4_q.groups);
          end
          if (v4_q.digits == V4_MAX_DIGITS) begin
            v4_d.failed = 1'b1;
          end else begin
            v4_d.digits = v4_q.digits + 2'd1;
          end
        end
        CLS_DOT: begin
          if (v4_q.digits == 2'd0 || v4_q.groups == V4_GROUPS) begin
            v4_d.failed = 1'b1;
          end else begin
            v4_d.digits = 2'd0;
          end
        end
        CLS_END: v4_d = v4_q;
        default: v4_d.failed = 1'b1;
      endcase
    end
  end

  // Colon-hex checker step; a held colon is resolved before the new class.
  always_comb begin
    v6_nxt    = v6_q;
    stop      = v6_q.failed;
    digit_sum = '0;
    if (!stop && v6_q.colon_pending) begin
      v6_nxt.colon_pending = 1'b0;
      if (head_i.cls == CLS_COLON) begin
        if (v6_q.seen_double) begin
          v6_nxt.failed = 1'b1;
        end else begin
          v6_nxt.seen_double  = 1'b1;
          v6_nxt.colon_groups = sat_inc4(v6_q.colon_groups);
          v6_nxt.dec_cnt      = '0;
          v6_nxt.hex_cnt      = '0;
        end
        stop = 1'b1;
      end else if (!v6_q.seen_double && v6_q.dec_cnt == '0 && v6_q.hex_cnt == '0) begin
        v6_nxt.failed = 1'b1;
        stop          = 1'b1;
      end else begin
        v6_nxt.colon_groups = sat_inc4(v6_q.colon_groups);
        v6_nxt.dec_cnt      = '0;
        v6_nxt.hex_cnt      = '0;
      end
    end
    v6_d = v6_nxt;
    if (!stop) begin
      digit_sum = {1'b0, v6_nxt.dec_cnt} + {1'b0, v6_nxt.hex_cnt};
      priority if (head_i.cls == CLS_DEC) begin
        v6_d.dec_cnt = sat_inc3(v6_nxt.dec_cnt);
      end else if (head_i.cls == CLS_HEX) begin
        v6_d.hex_cnt = sat_inc3(v6_nxt.hex_cnt);
      end else if (head_i.cls == CLS_COLON ||
                   (head_i.cls == CLS_END && v6_nxt.dot_groups == '0)) begin
        // Close a hex group at a colon or at the end of a pure hex string.
        if (v6_nxt.dot_groups != '0 || digit_sum > V6_GROUP_DIGITS ||
            (!v6_nxt.seen_double && v6_nxt.colon_groups == V6_GROUPS_FULL) ||
            (v6_nxt.seen_double && v6_nxt.colon_groups == V6_GROUPS_DOUBLE)) begin
          v6_d.failed = 1'b1;
        end else if (head_i.cls == CLS_COLON) begin
          v6_d.colon_pending = 1'b1;
        end else if (!v6_nxt.seen_double && v6_nxt.dec_cnt == '0 &&
                     v6_nxt.hex_cnt == '0) begin
          v6_d.failed = 1'b1;
        end else begin
          v6_d.colon_groups = sat_inc4(v6_nxt.colon_groups);
          v6_d.dec_cnt      = '0;
          v6_d.hex_cnt      = '0;
        end
      end else if (head_i.cls == CLS_DOT || head_i.cls == CLS_END) begin
        // Close one group of the dotted tail.
        if (v6_nxt.colon_groups == '0 || v6_nxt.colon_groups > V6_TAIL_MAX_GROUPS ||
            v6_nxt.hex_cnt != '0 || v6_nxt.dec_cnt > V6_TAIL_DEC_MAX) begin
          v6_d.failed = 1'b1;
        end else begin
          v6_d.dot_groups = sat_inc3(v6_nxt.dot_groups);
          v6_d.dec_cnt    = '0;
        end
      end else begin
        v6_d.failed = 1'b1;
      end
    end
  end

  // Final verdict from the state after the terminator was applied.
  always_comb begin
    ok4 = !v4_q.failed && v4_q.groups == V4_GROUPS;
    ok6 = !v6_d.failed;
    if (ok6 && v6_d.dot_groups != '0 && v6_d.dot_groups != V6_TAIL_GROUPS) begin
      ok6 = 1'b0;
    end
    if (ok6 && !v6_d.seen_double) begin
      if ((v6_d.dot_groups == '0 && v6_d.colon_groups != V6_GROUPS_FULL) ||
          (v6_d.dot_groups == V6_TAIL_GROUPS &&
           v6_d.colon_groups != V6_TAIL_MAX_GROUPS)) begin
        ok6 = 1'b0;
      end
    end
  end

  // Result register: loaded at a terminator, cleared when the result is popped.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (deq_o && is_end) begin
      out_valid_d = 1'b1;
      out_d.v4    = ok4;
      out_d.v6    = ok6;
      out_d.any   = ok4 || ok6;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q        <= '0;
      v6_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (deq_o) begin
        if (is_end) begin
          v4_q <= '0;
          v6_q <= '0;
        end else begin
          v4_q <= v4_d;
          v6_q <= v6_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: rtl/ipv_checker.sv
// Port-level checker of the address text validator, bound to its top level.
// Depends on ip_address_text_validator_assert.svh and ip_address_text_validator.
`include "ip_address_text_validator_assert.svh"

module ipv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input logic valid_v4_o,
  input logic valid_v6_o,
  input logic valid_any_o
);

  logic       res_wait;
  logic [2:0] res_bits;
  logic       any_ok;
  logic       both_set;

  // A result waits while it is shown and not taken.
  assign res_wait = !empty && !pop;
  assign res_bits = {valid_v4_o, valid_v6_o, valid_any_o};
  assign any_ok   = (valid_any_o == (valid_v4_o || valid_v6_o));
  assign both_set = valid_v4_o && valid_v6_o;

  // A waiting result stays until it is taken, and its payload holds.
  `IPV_ASSERT_NEXT(a_res_held, clk_i, rst_ni, res_wait, !empty, "result dropped")
  `IPV_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, res_wait, $stable(res_bits), "result changed")

  // The combined flag is the OR of the two form flags.
  `IPV_ASSERT_SAME(a_any_or, clk_i, rst_ni, !empty, any_ok, "combined flag mismatch")

  // A string cannot be both a dotted quad and a colon-hex address.
  `IPV_ASSERT_SAME(a_forms_excl, clk_i, rst_ni, !empty, !both_set, "both forms valid")

endmodule

bind ip_address_text_validator ipv_checker u_ipv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .valid_v4_o (valid_v4_o),
  .valid_v6_o (valid_v6_o),
  .valid_any_o(valid_any_o)
);

FILE: dv/ip_address_text_validator_tb.sv
// Self-checking testbench for the IPv4/IPv6 address text validator.
// Depends on ipv_pkg and ip_address_text_validator; a built-in predictor
// computes the verdict of every string and a monitor checks each one.
module ip_address_text_validator_tb import ipv_pkg::*;;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] text_char_i;
  logic       empty;
  logic       pop;
  logic       valid_v4_o;
  logic       valid_v6_o;
  logic       valid_any_o;

  // Predictor state of the dotted-quad check.
  logic [1:0] v4_digits;
  logic [2:0] v4_groups;
  logic       v4_bad;

  // Predictor state of the colon-hex check.
  logic [2:0] v6_dec;
  logic [2:0] v6_hex;
  logic [3:0] v6_groups;
  logic [2:0] v6_dots;
  logic       v6_double;
  logic       v6_pend;
  logic       v6_bad;

  verdict_t   verdicts_due[$];
  logic [7:0] text_buf[$];
  int         mismatches = 0;
  int         chars_sent = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         recv_hold_left = 0;

  ip_address_text_validator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_char_i (text_char_i),
    .empty       (empty),
    .pop         (pop),
    .valid_v4_o  (valid_v4_o),
    .valid_v6_o  (valid_v6_o),
    .valid_any_o (valid_any_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #5000000;
    $display("ip_address_text_validator regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [2:0] bump3(input logic [2:0] v);
    return (v == 3'd7) ? v : v + 3'd1;
  endfunction

  function automatic logic [3:0] bump4(input logic [3:0] v);
    return (v == 4'd15) ? v : v + 4'd1;
  endfunction

  function automatic bit is_dec_char(input logic [7:0] c);
    return c >= CHAR_0 && c <= CHAR_9;
  endfunction

  function automatic bit is_hex_letter(input logic [7:0] c);
    return (c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF);
  endfunction

  function automatic void clear_addr_state();
    v4_digits = '0;
    v4_groups = '0;
    v4_bad    = 1'b0;
    v6_dec    = '0;
    v6_hex    = '0;
    v6_groups = '0;
    v6_dots   = '0;
    v6_double = 1'b0;
    v6_pend   = 1'b0;
    v6_bad    = 1'b0;
  endfunction

  // Dotted-quad check: groups of one to three digits split by single dots.
  function automatic void v4_feed(input logic [7:0] c);
    if (v4_bad) return;
    if (is_dec_char(c)) begin
      if (v4_digits == 2'd0) v4_groups = bump3(v4_groups);
      if (v4_digits == V4_MAX_DIGITS) v4_bad = 1'b1;
      else v4_digits = v4_digits + 2'd1;
    end else if (c == CHAR_DOT) begin
      if (v4_digits == 2'd0 || v4_groups == V4_GROUPS) v4_bad = 1'b1;
      else v4_digits = 2'd0;
    end else begin
      v4_bad = 1'b1;
    end
  endfunction

  function automatic void v6_close_group();
    v6_groups = bump4(v6_groups);
    v6_dec    = '0;
    v6_hex    = '0;
  endfunction

  // Colon-hex check; a colon waits one character to spot a double colon.
  function automatic void v6_feed(input logic [7:0] c);
    if (v6_bad) return;
    if (v6_pend) begin
      v6_pend = 1'b0;
      if (c == CHAR_COLON) begin
        if (v6_double) begin
          v6_bad = 1'b1;
          return;
        end
        v6_double = 1'b1;
        v6_close_group();
        return;
      end
      if (!v6_double && v6_dec == 3'd0 && v6_hex == 3'd0) begin
        v6_bad = 1'b1;
        return;
      end
      v6_close_group();
    end
    if (is_dec_char(c)) begin
      v6_dec = bump3(v6_dec);
    end else if (is_hex_letter(c)) begin
      v6_hex = bump3(v6_hex);
    end else if (c == CHAR_COLON || (c == CHAR_NUL && v6_dots == 3'd0)) begin
      if (v6_dots != 3'd0 || int'(v6_dec) + int'(v6_hex) > int'(V6_GROUP_DIGITS) ||
          (!v6_double && v6_groups == V6_GROUPS_FULL) ||
          (v6_double && v6_groups == V6_GROUPS_DOUBLE)) begin
        v6_bad = 1'b1;
        return;
      end
      if (c == CHAR_COLON) begin
        v6_pend = 1'b1;
      end else begin
        if (!v6_double && v6_dec == 3'd0 && v6_hex == 3'd0) begin
          v6_bad = 1'b1;
          return;
        end
        v6_close_group();
      end
    end else if (c == CHAR_DOT || c == CHAR_NUL) begin
      if (v6_groups == 4'd0 || v6_groups > V6_TAIL_MAX_GROUPS ||
          v6_hex != 3'd0 || v6_dec > V6_TAIL_DEC_MAX) begin
        v6_bad = 1'b1;
        return;
      end
      v6_dots = bump3(v6_dots);
      v6_dec  = '0;
    end else begin
      v6_bad = 1'b1;
    end
  endfunction

  // Feeds one accepted character; the terminator queues a verdict.
  function automatic void predict_char(input logic [7:0] c);
    verdict_t vr;
    if (c != CHAR_NUL) begin
      v4_feed(c);
      v6_feed(c);
      return;
    end
    v6_feed(CHAR_NUL);
    vr.v4 = !v4_bad && v4_groups == V4_GROUPS;
    vr.v6 = !v6_bad;
    if (vr.v6 && v6_dots != 3'd0 && v6_dots != V6_TAIL_GROUPS) vr.v6 = 1'b0;
    if (vr.v6 && !v6_double) begin
      if ((v6_dots == 3'd0 && v6_groups != V6_GROUPS_FULL) ||
          (v6_dots == V6_TAIL_GROUPS && v6_groups != V6_TAIL_MAX_GROUPS))
        vr.v6 = 1'b0;
    end
    vr.any = vr.v4 | vr.v6;
    verdicts_due.push_back(vr);
    clear_addr_state();
  endfunction

  // ---------------------------------------------------------------------
  // Result monitor and receiver
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Each popped verdict is compared with the oldest prediction.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict popped with none predicted");
      end else begin
        want = verdicts_due.pop_front();
        if (valid_v4_o !== want.v4)
          report_mismatch($sformatf("valid_v4 got %b want %b", valid_v4_o, want.v4));
        if (valid_v6_o !== want.v6)
          report_mismatch($sformatf("valid_v6 got %b want %b", valid_v6_o, want.v6));
        if (valid_any_o !== want.any)
          report_mismatch($sformatf("valid_any got %b want %b", valid_any_o, want.any));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold_left > 0) begin
        pop <= 1'b0;
        recv_hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender and text generators
  // ---------------------------------------------------------------------

  // Offers one character and returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    text_char_i <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_char(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // Sends the buffered text followed by its terminator.
  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i]);
    send_char(CHAR_NUL);
    text_buf.delete();
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Holds the sender until every predicted verdict has been popped.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(2))
      0: return CHAR_0 + 8'($urandom_range(9));
      1: return CHAR_LA + 8'($urandom_range(5));
      default: return CHAR_UA + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic void put_hex_groups(input int n);
    int len;
    for (int g = 0; g < n; g++) begin
      if (g > 0) text_buf.push_back(CHAR_COLON);
      len = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
      repeat (len) text_buf.push_back(rand_hex_char());
    end
  endfunction

  // Mostly four dotted groups of one to three digits, sometimes off by a bit.
  function automatic void put_dotted_quad();
    int groups;
    int len;
    groups = ($urandom_range(4) == 0) ? $urandom_range(2, 5) : 4;
    for (int g = 0; g < groups; g++) begin
      if (g > 0) text_buf.push_back(CHAR_DOT);
      len = ($urandom_range(5) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 3);
      repeat (len) text_buf.push_back(CHAR_0 + 8'($urandom_range(9)));
    end
  endfunction

  // Full or compressed colon-hex text, a quarter of it with a dotted tail.
  function automatic void gen_v6_text();
    bit tail;
    int total;
    int head;
    tail = ($urandom_range(3) == 0);
    if ($urandom_range(1) == 1) begin
      total = $urandom_range(0, tail ? 6 : 8);
      head  = $urandom_range(0, total);
      put_hex_groups(head);
      text_buf.push_back(CHAR_COLON);
      text_buf.push_back(CHAR_COLON);
      put_hex_groups(total - head);
      if (tail) begin
        if (total > head) text_buf.push_back(CHAR_COLON);
        put_dotted_quad();
      end
    end else begin
      total = tail ? 6 : 8;
      if ($urandom_range(4) == 0) total = $urandom_range(1, 9);
      put_hex_groups(total);
      if (tail) begin
        text_buf.push_back(CHAR_COLON);
        put_dotted_quad();
      end
    end
  endfunction

  // Arbitrary bytes mixed with separators and digits.
  function automatic void gen_noise_text();
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(4))
        0: text_buf.push_back(CHAR_DOT);
        1: text_buf.push_back(CHAR_COLON);
        2: text_buf.push_back(rand_hex_char());
        default: text_buf.push_back(8'($urandom_range(1, 255)));
      endcase
    end
  endfunction

  // Picks a text form, then sometimes breaks one character of it.
  function automatic void gen_random_text();
    int pick;
    int pos;
    pick = $urandom_range(99);
    if (pick < 35) put_dotted_quad();
    else if (pick < 85) gen_v6_text();
    else gen_noise_text();
    if ($urandom_range(99) < 15 && text_buf.size() != 0) begin
      pos = $urandom_range(text_buf.size() - 1);
      case ($urandom_range(2))
        0: text_buf[pos] = 8'($urandom_range(1, 255));
        1: text_buf.insert(pos, ($urandom_range(1) == 1) ? CHAR_COLON : CHAR_DOT);
        default: text_buf.delete(pos);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Boundary strings of both forms and the corner cases of each check.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_string("");
    send_string("0.0.0.0");
    send_string("999.255.0.1");
    send_string("1.2.3");
    send_string("1.2.3.4.5");
    send_string("1234.1.1.1");
    send_string("1..2.3");
    send_string("\377.1.2.3");
    send_string("1.2.3.4\200");
    send_string("::");
    send_string("::1");
    send_string("1:2:3:4:5:6:7:8");
    send_string("1:2:3:4:5:6:7:8:9");
    send_string("1::2::3");
    send_string("fFfF:AbCd:0:0:0:0:0:1");
    send_string("12345::1");
    send_string("::ffff:1.2.3.4");
    send_string("1:2:3:4:5:6:1.2.3.4");
    send_string("1:2:3:4:5:6:7:1.2.3.4");
    send_string("::1..2.");
    send_string(":1:2:3:4:5:6:7");
    send_string("1:2:3:4:5:6:7:");
    send_string("g::1");
    send_string("11111111111111111111");
    send_string("abcdefABCDEFabcdef:1");
    wait_for_drain();
  endtask

  // Random text under one sender idle rate and one receiver stall rate.
  task automatic test_random_text(input int idle_pct, input int stall_pct, input int n);
    int first;
    first          = chars_sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (chars_sent - first < n) begin
      gen_random_text();
      send_text();
    end
    wait_for_drain();
  endtask

  // Receiver holds off while short strings keep arriving, so full must rise.
  task automatic test_queue_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = 300;
    repeat (40) begin
      put_dotted_quad();
      send_text();
    end
    wait_for_drain();
  endtask

  // Main sequence.
  initial begin
    push        = 1'b0;
    text_char_i = CHAR_NUL;
    rst_ni      = 1'b0;
    clear_addr_state();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_text(0, 0, 280);
    test_random_text(88, 0, 280);
    test_random_text(0, 88, 280);
    test_random_text(22, 22, 280);
    test_queue_fill();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("ip_address_text_validator regression: pass");
    else
      $display("ip_address_text_validator regression: fail");
    $finish;
  end

endmodule

FILE: ip_address_text_validator.f
+incdir+rtl
rtl/ipv_pkg.sv
rtl/ipv_front.sv
rtl/ipv_back.sv
rtl/ip_address_text_validator.sv
rtl/ipv_checker.sv
dv/ip_address_text_validator_tb.sv
